@@ sv/lzwc_pkg.sv @@
// Shared types and constants of the LZW byte compressor.
package lzwc_pkg;

  localparam int unsigned BASE_CODES     = 256;
  localparam int unsigned START_WIDTH    = 8;
  localparam int unsigned MAX_WIDTH      = 16;
  localparam int unsigned CODE_W         = 16;
  localparam int unsigned LEN_W          = 32;
  localparam int unsigned MAX_STEP_BYTES = 4;

  // One message byte as the back end sees it
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
    logic       first;
  } in_item_t;

  // One packed output byte
  typedef struct packed {
    logic [7:0]       packed_byte;
    logic             final_byte;
    logic [LEN_W-1:0] compressed_length;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT,
    ST_ADD,
    ST_PAD,
    ST_FLUSH
  } back_state_e;

endpackage

@@ sv/lzw_byte_compressor.sv @@
// Top level of the LZW byte compressor.
//
//  channel  | handshake        | beat
//  ---------+------------------+-----------------------------------------------
//  input    | push / full      | data_byte_i, end_of_message_i
//  result   | pop / empty      | packed_byte_o, final_byte_o, compressed_length_o
//
// A byte leaves the input queue and goes into the dictionary scan, one memory
// read a cycle; emitted codes are shifted out bit by bit while the result queue
// has room, followed by the add or, at the end of a message, the final pad; the
// dictionary scan, one read a cycle, sets the rate.
// Reset returns the dictionary to its 256 base codes; no clearing pass.
// A full result queue stalls bit packing; the two-entry input queue keeps
// taking bytes while the back end works.
module lzw_byte_compressor #(
  parameter int unsigned DICT_ENTRIES = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_message_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  packed_byte_o,
  output logic        final_byte_o,
  output logic [31:0] compressed_length_o
);

  lzwc_pkg::in_item_t  item;
  logic                item_valid, item_take;
  lzwc_pkg::out_item_t bk_item, q_item;
  logic                out_push, out_full;

  lzwc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .data_byte_i (data_byte_i),
    .last_i      (end_of_message_i),
    .full_o      (full),
    .item_o      (item),
    .item_valid_o(item_valid),
    .item_take_i (item_take)
  );

  lzwc_back #(
    .DICT_ENTRIES(DICT_ENTRIES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item),
    .item_valid_i(item_valid),
    .item_take_o (item_take),
    .out_push_o  (out_push),
    .out_item_o  (bk_item),
    .out_full_i  (out_full)
  );

  // Result queue
  lzwc_fifo #(
    .W    ($bits(lzwc_pkg::out_item_t)),
    .DEPTH(4)
  ) u_out_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (out_push),
    .data_i (bk_item),
    .full_o (out_full),
    .pop_i  (pop),
    .data_o (q_item),
    .empty_o(empty)
  );

  assign packed_byte_o       = q_item.packed_byte;
  assign final_byte_o        = q_item.final_byte;
  assign compressed_length_o = q_item.compressed_length;

  // The back end never pushes into a full result queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_push |-> !out_full) else $error("result pushed while queue full");

  // A final beat always reports a nonzero length
  a_final_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && final_byte_o) |-> (compressed_length_o != 32'd0))
    else $error("final beat with zero length");

  // Non-final beats carry no length
  a_mid_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !final_byte_o) |-> (compressed_length_o == 32'd0))
    else $error("length on a non-final beat");

endmodule

@@ sv/lzwc_fifo.sv @@
// Small first-in first-out queue of fixed-width words.
module lzwc_fifo #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic [W-1:0] data_o,
  output logic         empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [W-1:0]  slot_q [DEPTH];
  logic [PW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = slot_q[rd_q];

  // Advance pointers with wrap at the depth
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
    if (do_pop)  rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
    if (do_push && !do_pop) cnt_d = cnt_q + CW'(1);
    if (!do_push && do_pop) cnt_d = cnt_q - CW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Store the incoming beat
  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wr_q] <= data_i;
  end

endmodule

@@ sv/lzwc_front.sv @@
// Input queue of the compressor; tags the first byte of each message.
module lzwc_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  logic [7:0]         data_byte_i,
  input  logic               last_i,
  output logic               full_o,
  output lzwc_pkg::in_item_t item_o,
  output logic               item_valid_o,
  input  logic               item_take_i
);

  logic [8:0] q_data;
  logic       q_empty;
  logic       first_q, first_d;

  lzwc_fifo #(
    .W    (9),
    .DEPTH(2)
  ) u_in_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push_i),
    .data_i ({data_byte_i, last_i}),
    .full_o (full_o),
    .pop_i  (item_take_i),
    .data_o (q_data),
    .empty_o(q_empty)
  );

  // Classify: a byte after a final byte (or after reset) opens a message
  always_comb begin
    item_o.data_byte = q_data[8:1];
    item_o.last      = q_data[0];
    item_o.first     = first_q;
    item_valid_o     = !q_empty;
    first_d          = first_q;
    if (item_take_i && !q_empty) first_d = q_data[0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) first_q <= 1'b1;
    else         first_q <= first_d;
  end

endmodule

@@ sv/lzwc_back.sv @@
// Dictionary search, code emission and bit packing of the compressor.
module lzwc_back #(
  parameter int unsigned DICT_ENTRIES = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lzwc_pkg::in_item_t  item_i,
  input  logic                item_valid_i,
  output logic                item_take_o,
  output logic                out_push_o,
  output lzwc_pkg::out_item_t out_item_o,
  input  logic                out_full_i
);

  localparam int unsigned AW  = $clog2(DICT_ENTRIES);
  localparam int unsigned ECW = $clog2(DICT_ENTRIES + 1);
  localparam int unsigned CW  = lzwc_pkg::CODE_W;
  localparam int unsigned LW  = lzwc_pkg::LEN_W;

  lzwc_pkg::back_state_e state_q, state_d;

  logic [AW+7:0]  dict_mem [DICT_ENTRIES];
  logic [AW+7:0]  rd_q;
  logic           mem_we, mem_re;
  logic [AW-1:0]  waddr, raddr;
  logic [AW+7:0]  wdata;

  logic [7:0]     sym_q, sym_d;
  logic           last_q, last_d;
  logic [AW-1:0]  prefix_q, prefix_d;
  logic [ECW-1:0] count_q, count_d;
  logic [4:0]     cw_q, cw_d, cw_n;
  logic [CW-1:0]  code_q, code_d;
  logic [3:0]     idx_q, idx_d;
  logic           fin_q, fin_d;
  logic [ECW-1:0] issue_q, issue_d;
  logic           cmp_v_q, cmp_v_d;
  logic [AW-1:0]  cmp_idx_q, cmp_idx_d;
  logic [7:0]     partial_q, partial_d;
  logic [2:0]     fill_q, fill_d;
  logic [LW-1:0]  bytes_q, bytes_d;
  logic [7:0]     hold_q, hold_d;
  logic           hold_v_q, hold_v_d;
  logic [2:0]     nprod_q, nprod_d;
  logic           prod_v;
  logic [7:0]     prod_byte;

  always_comb begin
    state_d     = state_q;
    sym_d       = sym_q;
    last_d      = last_q;
    prefix_d    = prefix_q;
    count_d     = count_q;
    cw_d        = cw_q;
    cw_n        = cw_q;
    code_d      = code_q;
    idx_d       = idx_q;
    fin_d       = fin_q;
    issue_d     = issue_q;
    cmp_v_d     = cmp_v_q;
    cmp_idx_d   = cmp_idx_q;
    partial_d   = partial_q;
    fill_d      = fill_q;
    bytes_d     = bytes_q;
    hold_d      = hold_q;
    hold_v_d    = hold_v_q;
    nprod_d     = nprod_q;
    item_take_o = 1'b0;
    out_push_o  = 1'b0;
    out_item_o  = '0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    waddr       = count_q[AW-1:0];
    raddr       = issue_q[AW-1:0];
    wdata       = {prefix_q, sym_q};
    prod_v      = 1'b0;
    prod_byte   = '0;

    case (state_q)
      // Take the next byte; a first byte becomes the prefix, and is emitted if also last
      lzwc_pkg::ST_IDLE: begin
        if (item_valid_i) begin
          item_take_o = 1'b1;
          sym_d       = item_i.data_byte;
          last_d      = item_i.last;
          if (item_i.first) begin
            prefix_d = AW'(item_i.data_byte);
            if (item_i.last) begin
              code_d  = CW'(item_i.data_byte);
              idx_d   = 4'(cw_q - 5'd1);
              fin_d   = 1'b1;
              state_d = lzwc_pkg::ST_EMIT;
            end
          end else begin
            issue_d = ECW'(lzwc_pkg::BASE_CODES);
            cmp_v_d = 1'b0;
            state_d = lzwc_pkg::ST_SCAN;
          end
        end
      end
      // Read one entry a cycle, compare the one read the cycle before
      lzwc_pkg::ST_SCAN: begin
        if (cmp_v_q && rd_q == {prefix_q, sym_q}) begin
          prefix_d = cmp_idx_q;
          if (last_q) begin
            code_d  = CW'(cmp_idx_q);
            idx_d   = 4'(cw_q - 5'd1);
            fin_d   = 1'b1;
            state_d = lzwc_pkg::ST_EMIT;
          end else begin
            state_d = lzwc_pkg::ST_IDLE;
          end
        end else if (issue_q < count_q) begin
          mem_re    = 1'b1;
          cmp_idx_d = issue_q[AW-1:0];
          cmp_v_d   = 1'b1;
          issue_d   = issue_q + ECW'(1);
        end else if (!cmp_v_q) begin
          code_d  = CW'(prefix_q);
          idx_d   = 4'(cw_q - 5'd1);
          fin_d   = 1'b0;
          state_d = lzwc_pkg::ST_EMIT;
        end else begin
          cmp_v_d = 1'b0;
        end
      end
      // Shift one code bit a cycle into the partial byte while the result queue is not full
      lzwc_pkg::ST_EMIT: begin
        if (!out_full_i) begin
          partial_d = {partial_q[6:0], code_q[idx_q]};
          fill_d    = fill_q + 3'd1;
          if (fill_q == 3'd7) begin
            prod_v    = 1'b1;
            prod_byte = partial_d;
            partial_d = '0;
          end
          idx_d = idx_q - 4'd1;
          if (idx_q == 4'd0) state_d = fin_q ? lzwc_pkg::ST_PAD : lzwc_pkg::ST_ADD;
        end
      end
      // Add (prefix, byte) while room remains, widen codes at a power of two
      lzwc_pkg::ST_ADD: begin
        prefix_d = AW'(sym_q);
        if (count_q < ECW'(DICT_ENTRIES)) begin
          mem_we = 1'b1;
          if (cw_q < 5'(lzwc_pkg::MAX_WIDTH) && (32'(count_q) >> cw_q) != 32'd0) begin
            cw_n = cw_q + 5'd1;
          end
          count_d = count_q + ECW'(1);
        end
        cw_d = cw_n;
        if (last_q) begin
          code_d  = CW'(sym_q);
          idx_d   = 4'(cw_n - 5'd1);
          fin_d   = 1'b1;
          state_d = lzwc_pkg::ST_EMIT;
        end else begin
          state_d = lzwc_pkg::ST_IDLE;
        end
      end
      // Zero-pad the partial byte
      lzwc_pkg::ST_PAD: begin
        if (!out_full_i) begin
          if (fill_q != 3'd0) begin
            prod_v    = 1'b1;
            prod_byte = 8'(partial_q << (4'd8 - {1'b0, fill_q}));
          end
          partial_d = '0;
          fill_d    = '0;
          state_d   = lzwc_pkg::ST_FLUSH;
        end
      end
      // Release the held byte as the final beat, then clear message state
      lzwc_pkg::ST_FLUSH: begin
        if (!out_full_i) begin
          out_push_o                   = 1'b1;
          out_item_o.packed_byte       = hold_q;
          out_item_o.final_byte        = 1'b1;
          out_item_o.compressed_length = bytes_q;
          count_d  = ECW'(lzwc_pkg::BASE_CODES);
          cw_d     = 5'(lzwc_pkg::START_WIDTH);
          bytes_d  = '0;
          hold_v_d = 1'b0;
          nprod_d  = '0;
          state_d  = lzwc_pkg::ST_IDLE;
        end
      end
      default: state_d = lzwc_pkg::ST_IDLE;
    endcase

    // Route a finished byte: straight out, or through the hold register on the last byte
    if (prod_v) begin
      if (bytes_q != '1) bytes_d = bytes_q + LW'(1);
      if (!last_q) begin
        out_push_o             = 1'b1;
        out_item_o.packed_byte = prod_byte;
      end else if (!hold_v_q) begin
        hold_d   = prod_byte;
        hold_v_d = 1'b1;
        nprod_d  = 3'd1;
      end else if (nprod_q < 3'(lzwc_pkg::MAX_STEP_BYTES)) begin
        out_push_o             = 1'b1;
        out_item_o.packed_byte = hold_q;
        hold_d                 = prod_byte;
        nprod_d                = nprod_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= lzwc_pkg::ST_IDLE;
      count_q  <= ECW'(lzwc_pkg::BASE_CODES);
      cw_q     <= 5'(lzwc_pkg::START_WIDTH);
      cmp_v_q  <= 1'b0;
      fill_q   <= '0;
      partial_q <= '0;
      bytes_q  <= '0;
      hold_v_q <= 1'b0;
      nprod_q  <= '0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      cw_q     <= cw_d;
      cmp_v_q  <= cmp_v_d;
      fill_q   <= fill_d;
      partial_q <= partial_d;
      bytes_q  <= bytes_d;
      hold_v_q <= hold_v_d;
      nprod_q  <= nprod_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    sym_q     <= sym_d;
    last_q    <= last_d;
    prefix_q  <= prefix_d;
    code_q    <= code_d;
    idx_q     <= idx_d;
    fin_q     <= fin_d;
    issue_q   <= issue_d;
    cmp_idx_q <= cmp_idx_d;
    hold_q    <= hold_d;
  end

  // Dictionary memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) dict_mem[waddr] <= wdata;
    if (mem_re) rd_q <= dict_mem[raddr];
  end

endmodule
